// ===== hw/rtl/hbc_pkg.sv =====
`timescale 1ns / 1ps
package hbc_pkg;

	localparam int FRAC_BITS_DEF = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int WEIGHT_W   = 11;
	localparam int SPEED_W    = 16;
	localparam int COUNT_W    = 12;
	localparam int HALL_W     = 3;
	localparam int PAIR_W     = 3;
	localparam int PROD_W     = WEIGHT_W + SPEED_W;
	localparam int DIV_CNT_W  = 4;

	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [0:0]          RST_START_ENABLE   = 1'b0;
	localparam logic [1:0]          RST_DIRECTION_MODE = 2'd1;
	localparam logic [WEIGHT_W-1:0] RST_FILTER_K_NEW   = 11'd355;
	localparam logic [WEIGHT_W-1:0] RST_FILTER_K_OLD   = 11'd669;
	localparam logic [SPEED_W-1:0]  RST_RATE_NUM       = 16'd16384;
	localparam logic [COUNT_W-1:0]  RST_STALL_LIMIT    = 12'd2000;

	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	localparam logic [HALL_W-1:0] HALL_BAD_LO = 3'd0;
	localparam logic [HALL_W-1:0] HALL_BAD_HI = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_ENABLE   = 3'd0,
		REG_DIRECTION_MODE = 3'd1,
		REG_FILTER_K_NEW   = 3'd2,
		REG_FILTER_K_OLD   = 3'd3,
		REG_RATE_NUM       = 3'd4,
		REG_STALL_LIMIT    = 3'd5
	} reg_idx_t;

	localparam logic [PAIR_W-1:0] FWD_PAIR [8] = '{3'd0, 3'd2, 3'd4, 3'd1, 3'd0, 3'd5, 3'd3, 3'd0};
	localparam logic [PAIR_W-1:0] REV_PAIR [8] = '{3'd0, 3'd3, 3'd5, 3'd0, 3'd1, 3'd4, 3'd2, 3'd0};

	typedef struct packed {
		logic                start_enable;
		logic [1:0]          direction_mode;
		logic [WEIGHT_W-1:0] filter_k_new;
		logic [WEIGHT_W-1:0] filter_k_old;
		logic [SPEED_W-1:0]  rate_num;
		logic [COUNT_W-1:0]  stall_limit;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic capture;
		logic eval;
		logic mix_a;
		logic mix_b;
		logic div_setup;
		logic div_step;
		logic mix_c;
		logic mix_d;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic run_change;
		logic div_needed;
		logic div_last;
	} status_t;

	function automatic logic code_valid(input logic [HALL_W-1:0] h);
		return (h != HALL_BAD_LO) && (h != HALL_BAD_HI);
	endfunction

	function automatic logic [SPEED_W-1:0] sat16(input logic [PROD_W:0] v);
		return (v > {{(PROD_W+1-SPEED_W){1'b0}}, SPEED_MAX}) ? SPEED_MAX : v[SPEED_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/hbc_ctrl.sv =====
`timescale 1ns / 1ps
module hbc_ctrl
	import hbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_free,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_EVAL      = 9'b000000010,
		S_MIX_A     = 9'b000000100,
		S_MIX_B     = 9'b000001000,
		S_DIV_SETUP = 9'b000010000,
		S_DIV       = 9'b000100000,
		S_MIX_C     = 9'b001000000,
		S_MIX_D     = 9'b010000000,
		S_DONE      = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.idle    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.run_change ? S_MIX_A : S_DONE;
			end
			S_MIX_A: begin
				cmd.mix_a = 1'b1;
				state_d   = S_MIX_B;
			end
			S_MIX_B: begin
				cmd.mix_b = 1'b1;
				state_d   = S_DIV_SETUP;
			end
			S_DIV_SETUP: begin
				cmd.div_setup = 1'b1;
				state_d       = status.div_needed ? S_DIV : S_MIX_C;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = S_MIX_C;
			end
			S_MIX_C: begin
				cmd.mix_c = 1'b1;
				state_d   = S_MIX_D;
			end
			S_MIX_D: begin
				cmd.mix_d = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				cmd.load_out = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/hbc_datapath.sv =====
`timescale 1ns / 1ps
module hbc_datapath
	import hbc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	input  logic [HALL_W-1:0]   hall_code,
	output status_t             status,
	output logic                apply_q,
	output logic [PAIR_W-1:0]   pair_q,
	output logic                stop_q,
	output logic [SPEED_W-1:0]  speed_value_q,
	output logic [SPEED_W-1:0]  speed_smoothed_q
);

	logic [HALL_W-1:0]    hall_q;
	logic [HALL_W-1:0]    prev_hall_q;
	logic [COUNT_W-1:0]   period_count_q;
	logic [SPEED_W-1:0]   count_filtered_q;
	logic                 valid_q;
	logic [PROD_W:0]      acc_q;
	logic [SPEED_W-1:0]   rem_q;
	logic [SPEED_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                 hall_ok;
	logic                 changed;
	logic                 pick_ok;
	logic [PAIR_W-1:0]    pick_pair;
	logic [COUNT_W-1:0]   count_inc;
	logic                 stall_hit;
	logic                 eval_apply;
	logic [PAIR_W-1:0]    eval_pair;
	logic                 eval_stop;
	logic [WEIGHT_W-1:0]  mul_a;
	logic [SPEED_W-1:0]   mul_b;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W:0]      prod_sh;
	logic [PROD_W:0]      mix_sum;
	logic [SPEED_W:0]     rem_trial;
	logic                 q_bit;
	logic [SPEED_W:0]     rem_diff;

	assign hall_ok = code_valid(hall_q);
	assign changed = hall_q != prev_hall_q;

	always_comb begin
		pick_ok   = 1'b0;
		pick_pair = '0;
		if (hall_ok && cfg.direction_mode == DIR_FWD) begin
			pick_ok   = 1'b1;
			pick_pair = FWD_PAIR[hall_q];
		end else if (hall_ok && cfg.direction_mode == DIR_REV) begin
			pick_ok   = 1'b1;
			pick_pair = REV_PAIR[hall_q];
		end
	end

	assign count_inc = (period_count_q == COUNT_MAX) ? period_count_q
	                                                 : period_count_q + 1'b1;
	assign stall_hit = count_inc >= cfg.stall_limit;

	always_comb begin
		eval_apply = 1'b0;
		eval_pair  = '0;
		eval_stop  = 1'b0;
		if (cfg.start_enable && changed) begin
			eval_apply = pick_ok;
			eval_pair  = pick_pair;
			eval_stop  = !hall_ok;
		end else if (cfg.start_enable && stall_hit) begin
			eval_apply = pick_ok;
			eval_pair  = pick_pair;
			eval_stop  = 1'b1;
		end
	end

	always_comb begin
		mul_a = cfg.filter_k_old;
		mul_b = count_filtered_q;
		if (cmd.mix_b) begin
			mul_a = cfg.filter_k_new;
			mul_b = {{(SPEED_W-COUNT_W){1'b0}}, period_count_q};
		end else if (cmd.mix_c) begin
			mul_a = cfg.filter_k_old;
			mul_b = speed_smoothed_q;
		end else if (cmd.mix_d) begin
			mul_a = cfg.filter_k_new;
			mul_b = speed_value_q;
		end
	end

	assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign prod_sh = {1'b0, prod} >> FRAC_BITS;
	assign mix_sum = acc_q + prod_sh;

	assign rem_trial = {rem_q, quo_q[SPEED_W-1]};
	assign rem_diff  = rem_trial - {1'b0, count_filtered_q};
	assign q_bit     = rem_trial >= {1'b0, count_filtered_q};

	assign status.run_change = cfg.start_enable && changed;
	assign status.div_needed = valid_q && (count_filtered_q != '0);
	assign status.div_last   = div_cnt_q == '1;

	always_ff @(posedge clk) begin
		if (cmd.capture) hall_q <= hall_code;
		if (cmd.eval) valid_q <= hall_ok;
		if (cmd.mix_a || cmd.mix_c) acc_q <= prod_sh;
		if (cmd.div_setup) begin
			rem_q     <= '0;
			quo_q     <= cfg.rate_num;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= q_bit ? rem_diff[SPEED_W-1:0] : rem_trial[SPEED_W-1:0];
			quo_q     <= {quo_q[SPEED_W-2:0], q_bit};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_hall_q      <= '0;
			period_count_q   <= '0;
			count_filtered_q <= '0;
			speed_value_q    <= '0;
			speed_smoothed_q <= '0;
			apply_q          <= 1'b0;
			pair_q           <= '0;
			stop_q           <= 1'b0;
		end else begin
			if (cmd.eval) begin
				prev_hall_q <= hall_q;
				apply_q     <= eval_apply;
				pair_q      <= eval_pair;
				stop_q      <= eval_stop;
				if (cfg.start_enable && !changed) begin
					period_count_q <= stall_hit ? '0 : count_inc;
					if (stall_hit) speed_smoothed_q <= '0;
				end
			end
			if (cmd.mix_b) begin
				count_filtered_q <= sat16(mix_sum);
				period_count_q   <= '0;
			end
			if (cmd.div_setup) begin
				if (!valid_q) speed_value_q <= '0;
				else if (count_filtered_q == '0) speed_value_q <= SPEED_MAX;
			end
			if (cmd.div_step && status.div_last) begin
				speed_value_q <= {quo_q[SPEED_W-2:0], q_bit};
			end
			if (cmd.mix_d) speed_smoothed_q <= sat16(mix_sum);
		end
	end

endmodule

// ===== hw/rtl/hall_bldc_commutator_speed.sv =====
`timescale 1ns / 1ps
// A disabled or unchanged hall code goes from accept straight to the result; a code change
// with an invalid code or a zero filtered count runs the filter steps but skips the divider,
// and any other code change also runs the restoring divider; the result load waits on output stall.
// The block takes one item at a time; the next item is taken in the cycle after the result loads.
// Reset (arst_n low) clears all measurement state and loads the register defaults.
module hall_bldc_commutator_speed
	import hbc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [HALL_W-1:0]     hall_code,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  drive_apply,
	output logic [PAIR_W-1:0]     drive_pair,
	output logic                  motor_stop,
	output logic [SPEED_W-1:0]    speed_raw,
	output logic [SPEED_W-1:0]    speed_filtered
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;
	logic    out_valid_q;
	logic    out_free;

	logic               apply_w;
	logic [PAIR_W-1:0]  pair_w;
	logic               stop_w;
	logic [SPEED_W-1:0] speed_value_w;
	logic [SPEED_W-1:0] speed_smoothed_w;

	logic               drive_apply_q;
	logic [PAIR_W-1:0]  drive_pair_q;
	logic               motor_stop_q;
	logic [SPEED_W-1:0] speed_raw_q;
	logic [SPEED_W-1:0] speed_filtered_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_enable   <= RST_START_ENABLE;
			cfg_q.direction_mode <= RST_DIRECTION_MODE;
			cfg_q.filter_k_new   <= RST_FILTER_K_NEW;
			cfg_q.filter_k_old   <= RST_FILTER_K_OLD;
			cfg_q.rate_num       <= RST_RATE_NUM;
			cfg_q.stall_limit    <= RST_STALL_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_ENABLE:   cfg_q.start_enable   <= cfg_data[0];
				REG_DIRECTION_MODE: cfg_q.direction_mode <= cfg_data[1:0];
				REG_FILTER_K_NEW:   cfg_q.filter_k_new   <= cfg_data[WEIGHT_W-1:0];
				REG_FILTER_K_OLD:   cfg_q.filter_k_old   <= cfg_data[WEIGHT_W-1:0];
				REG_RATE_NUM:       cfg_q.rate_num       <= cfg_data[SPEED_W-1:0];
				REG_STALL_LIMIT:    cfg_q.stall_limit    <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !cmd.idle;

	hbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd)
	);

	hbc_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.hall_code        (hall_code),
		.status           (status),
		.apply_q          (apply_w),
		.pair_q           (pair_w),
		.stop_q           (stop_w),
		.speed_value_q    (speed_value_w),
		.speed_smoothed_q (speed_smoothed_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			drive_apply_q    <= apply_w;
			drive_pair_q     <= pair_w;
			motor_stop_q     <= stop_w;
			speed_raw_q      <= speed_value_w;
			speed_filtered_q <= speed_smoothed_w;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_apply    = drive_apply_q;
	assign drive_pair     = drive_pair_q;
	assign motor_stop     = motor_stop_q;
	assign speed_raw      = speed_raw_q;
	assign speed_filtered = speed_filtered_q;

endmodule

// ===== test/tb_hall_bldc_commutator_speed.sv =====
`timescale 1ns / 1ps
module tb_hall_bldc_commutator_speed;
	import hbc_pkg::*;

	localparam logic [1:0] DIR_NONE_LO = 2'd0;
	localparam logic [1:0] DIR_NONE_HI = 2'd3;
	localparam logic [HALL_W-1:0] ROTATION [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 131;

	typedef struct packed {
		logic               apply;
		logic [PAIR_W-1:0]  pair;
		logic               stop;
		logic [SPEED_W-1:0] raw;
		logic [SPEED_W-1:0] filt;
	} drive_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [HALL_W-1:0]     hall_code = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  drive_apply;
	logic [PAIR_W-1:0]     drive_pair;
	logic                  motor_stop;
	logic [SPEED_W-1:0]    speed_raw;
	logic [SPEED_W-1:0]    speed_filtered;

	logic [HALL_W-1:0] hall_q [$];
	drive_result_t     drive_expect_q [$];
	int                mismatches = 0;
	int                feed_gap = 0;
	int                stall_left = 0;
	logic              steady = 1'b0;

	logic                c_enable = RST_START_ENABLE;
	logic [1:0]          c_dir    = RST_DIRECTION_MODE;
	logic [WEIGHT_W-1:0] c_knew   = RST_FILTER_K_NEW;
	logic [WEIGHT_W-1:0] c_kold   = RST_FILTER_K_OLD;
	logic [SPEED_W-1:0]  c_coeff  = RST_RATE_NUM;
	logic [COUNT_W-1:0]  c_limit  = RST_STALL_LIMIT;

	logic [HALL_W-1:0]  last_hall = '0;
	logic [COUNT_W-1:0] period_cnt = '0;
	logic [SPEED_W-1:0] period_avg = '0;
	logic [SPEED_W-1:0] speed_now = '0;
	logic [SPEED_W-1:0] speed_avg = '0;

	hall_bldc_commutator_speed DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hall_code(hall_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_apply(drive_apply),
		.drive_pair(drive_pair),
		.motor_stop(motor_stop),
		.speed_raw(speed_raw),
		.speed_filtered(speed_filtered)
	);

	initial forever #1 clk = ~clk;

	function automatic logic [SPEED_W-1:0] blend(input int unsigned old_v, input int unsigned new_v);
		int unsigned r;
		r = ((c_kold * old_v) >> FRAC_BITS_DEF) + ((c_knew * new_v) >> FRAC_BITS_DEF);
		return (r > SPEED_MAX) ? SPEED_MAX : r[SPEED_W-1:0];
	endfunction

	function automatic logic switch_pair(input logic [HALL_W-1:0] h, output logic [PAIR_W-1:0] p);
		p = '0;
		if (h == HALL_BAD_LO || h == HALL_BAD_HI)
			return 1'b0;
		if (c_dir == DIR_FWD) begin
			case (h)
				3'd1: p = 3'd2;
				3'd2: p = 3'd4;
				3'd3: p = 3'd1;
				3'd4: p = 3'd0;
				3'd5: p = 3'd5;
				default: p = 3'd3;
			endcase
			return 1'b1;
		end
		if (c_dir == DIR_REV) begin
			case (h)
				3'd1: p = 3'd3;
				3'd2: p = 3'd5;
				3'd3: p = 3'd0;
				3'd4: p = 3'd1;
				3'd5: p = 3'd4;
				default: p = 3'd2;
			endcase
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic drive_result_t commutate_period(input logic [HALL_W-1:0] h);
		drive_result_t r;
		logic          ok;
		logic [PAIR_W-1:0] p;
		r = '0;
		if (c_enable) begin
			if (h != last_hall) begin
				ok = (h != HALL_BAD_LO) && (h != HALL_BAD_HI);
				r.apply = switch_pair(h, p);
				r.pair = p;
				r.stop = !ok;
				period_avg = blend(period_avg, period_cnt);
				if (!ok)
					speed_now = '0;
				else if (period_avg == '0)
					speed_now = SPEED_MAX;
				else
					speed_now = c_coeff / period_avg;
				speed_avg = blend(speed_avg, speed_now);
				period_cnt = '0;
			end else begin
				if (period_cnt < COUNT_MAX)
					period_cnt = period_cnt + 1'b1;
				if (period_cnt >= c_limit) begin
					period_cnt = '0;
					speed_avg = '0;
					r.stop = 1'b1;
					r.apply = switch_pair(h, p);
					r.pair = p;
				end
			end
		end
		last_hall = h;
		r.raw = speed_now;
		r.filt = speed_avg;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			feed_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				drive_expect_q.push_back(commutate_period(hall_code));
			if (!in_valid || !in_stall) begin
				if (feed_gap != 0) begin
					feed_gap <= feed_gap - 1;
					in_valid <= 1'b0;
				end else if (hall_q.size() != 0 && !steady && $urandom_range(0, 9) == 0) begin
					feed_gap <= $urandom_range(0, 15);
					in_valid <= 1'b0;
				end else if (hall_q.size() != 0) begin
					in_valid <= 1'b1;
					hall_code <= hall_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		drive_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: expected none actual %0d %0d %0d %0d %0d",
						$time, drive_apply, drive_pair, motor_stop, speed_raw, speed_filtered);
				end else begin
					want = drive_expect_q.pop_front();
					check_field("drive_apply", want.apply, drive_apply);
					check_field("drive_pair", want.pair, drive_pair);
					check_field("motor_stop", want.stop, motor_stop);
					check_field("speed_raw", want.raw, speed_raw);
					check_field("speed_filtered", want.filt, speed_filtered);
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!steady && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_START_ENABLE:   c_enable = val[0];
			REG_DIRECTION_MODE: c_dir = val[1:0];
			REG_FILTER_K_NEW:   c_knew = val[WEIGHT_W-1:0];
			REG_FILTER_K_OLD:   c_kold = val[WEIGHT_W-1:0];
			REG_RATE_NUM:       c_coeff = val[SPEED_W-1:0];
			REG_STALL_LIMIT:    c_limit = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int unsigned en, input logic [1:0] dir, input int unsigned knew,
			input int unsigned kold, input int unsigned coeff, input int unsigned limit);
		write_reg(REG_START_ENABLE, en);
		write_reg(REG_DIRECTION_MODE, dir);
		write_reg(REG_FILTER_K_NEW, knew);
		write_reg(REG_FILTER_K_OLD, kold);
		write_reg(REG_RATE_NUM, coeff);
		write_reg(REG_STALL_LIMIT, limit);
	endtask

	task automatic drain();
		while (hall_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic int unsigned pick_weight();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 1024;
			default: return $urandom_range(0, 1024);
		endcase
	endfunction

	task automatic shuffle_config();
		logic [1:0]  dir;
		int unsigned coeff;
		int unsigned limit;
		case ($urandom_range(0, 7))
			0: dir = DIR_NONE_LO;
			1: dir = DIR_NONE_HI;
			2, 3, 4: dir = DIR_FWD;
			default: dir = DIR_REV;
		endcase
		case ($urandom_range(0, 3))
			0: coeff = 1;
			1: coeff = 65535;
			default: coeff = $urandom_range(1, 65535);
		endcase
		case ($urandom_range(0, 4))
			0: limit = 1;
			1: limit = 4095;
			default: limit = $urandom_range(2, 30);
		endcase
		write_all($urandom_range(0, 5) != 0, dir, pick_weight(), pick_weight(), coeff, limit);
	endtask

	task automatic fill_rotation(input int count);
		int pos;
		int step;
		int run;
		int cap;
		pos = $urandom_range(0, 5);
		step = $urandom_range(0, 1) ? 1 : 5;
		cap = (c_limit < 40) ? c_limit + 1 : 40;
		while (count > 0) begin
			case ($urandom_range(0, 9))
				0: begin
					hall_q.push_back(HALL_W'($urandom_range(0, 7)));
					count--;
				end
				1: step = 6 - step;
				default: begin
					run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap) : $urandom_range(0, 2);
					for (int i = 0; i <= run && count > 0; i++) begin
						hall_q.push_back(ROTATION[pos]);
						count--;
					end
					pos = (pos + step) % 6;
				end
			endcase
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		hall_q = '{3'd0, 3'd7, 3'd5};
		drain();
		write_all(1, DIR_FWD, 355, 669, 16384, 3);
		hall_q = '{3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1,
			3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd1};
		drain();
		write_all(1, DIR_REV, 1024, 1024, 65535, 1);
		hall_q = '{3'd3, 3'd3, 3'd5, 3'd4, 3'd4};
		drain();
		write_all(1, DIR_NONE_LO, 0, 0, 1, 4095);
		hall_q = '{3'd2, 3'd6};
		drain();
		write_reg(REG_DIRECTION_MODE, DIR_NONE_HI);
		hall_q = '{3'd5, 3'd5};
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			shuffle_config();
			if (ph == RANDOM_PHASES - 1)
				steady = 1'b1;
			fill_rotation(PHASE_ITEMS);
			drain();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0 && drive_expect_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== hall_bldc_commutator_speed.f =====
hw/rtl/hbc_pkg.sv
hw/rtl/hbc_ctrl.sv
hw/rtl/hbc_datapath.sv
hw/rtl/hall_bldc_commutator_speed.sv
test/tb_hall_bldc_commutator_speed.sv
